// File: rtl/pdpm_pkg.sv
package pdpm_pkg;

  localparam int unsigned MAP_DEPTH = 16;
  localparam int unsigned SLOT_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(MAP_DEPTH + 1);

  localparam int unsigned COORD_W  = 20;
  localparam int unsigned DIFF_W   = COORD_W + 1;
  localparam int unsigned PROD_W   = 2 * DIFF_W;
  localparam int unsigned SQ_W     = 2 * COORD_W;
  localparam int unsigned SUM_W    = SQ_W + 1;
  localparam int unsigned RADIUS_W = 42;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(65536);

  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned POINT_COUNT_W = 5;
  localparam int unsigned MATCH_SLOT_W  = 4;

  localparam int unsigned APB_ADDR_W  = 4;
  localparam int unsigned APB_DATA_W  = 64;
  localparam int unsigned REG_IDX_LSB = 3;
  localparam int unsigned REG_IDX_W   = APB_ADDR_W - REG_IDX_LSB;

  localparam logic [REG_IDX_W-1:0] REG_MATCH_RADIUS_SQ = REG_IDX_W'(0);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_ADDED     = 2'd0,
    STATUS_DUPLICATE = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

endpackage

// File: rtl/pdpm_if.sv
interface pdpm_in_if import pdpm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink (input valid, input point_x, input point_y, output ready);
endinterface

interface pdpm_out_if import pdpm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  status_e                  status;
  logic [POINT_COUNT_W-1:0] point_count;
  logic [MATCH_SLOT_W-1:0]  match_slot;

  modport source (output valid, output status, output point_count, output match_slot,
                  input ready);
  modport sink (input valid, input status, input point_count, input match_slot,
                output ready);
endinterface

// File: rtl/proximity_dedup_point_map_top.sv
// Flow: each accepted item scans the stored points in order, squaring the x
// difference in S_SQX and the y difference in S_SQY, and stops at the first match.
// One item is processed at a time (ready only in S_IDLE); the single 21x21 squarer is
// shared between the x and y differences.
// Reset: point count cleared, match radius set to one metre squared, output emptied;
// the point store itself is not cleared and needs no clearing pass.
module proximity_dedup_point_map_top import pdpm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pdpm_in_if.sink               in_i,
  pdpm_out_if.source            out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SQX   = 5'b00010,
    S_SQY   = 5'b00100,
    S_FINAL = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [RADIUS_W-1:0]       radius_q;
  logic signed [COORD_W-1:0] mem_x_q [MAP_DEPTH];
  logic signed [COORD_W-1:0] mem_y_q [MAP_DEPTH];
  logic [CNT_W-1:0]          count_q;
  logic signed [COORD_W-1:0] px_q, py_q;
  logic [SLOT_W-1:0]         idx_q;
  logic [SQ_W-1:0]           sqx_q, sqy_q;
  logic                      cmp_valid_q;
  logic [SLOT_W-1:0]         cmp_slot_q;

  status_e                   res_status_q;
  logic [CNT_W-1:0]          res_count_q;
  logic [SLOT_W-1:0]         res_slot_q;

  logic                      out_valid_q;
  status_e                   out_status_q;
  logic [POINT_COUNT_W-1:0]  out_count_q;
  logic [MATCH_SLOT_W-1:0]   out_slot_q;

  logic                      in_fire;
  logic                      cfg_write;
  logic [REG_IDX_W-1:0]      reg_idx;
  logic signed [DIFF_W-1:0]  diff_x, diff_y, mul_op;
  logic signed [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]          dist_sq;
  logic                      hit;
  logic                      last_slot;
  logic                      out_free;
  logic                      append;

  assign in_fire   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  assign reg_idx   = paddr[APB_ADDR_W-1:REG_IDX_LSB];
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign prdata    = (reg_idx == REG_MATCH_RADIUS_SQ) ? APB_DATA_W'(radius_q) : '0;

  // shared squarer: x difference in S_SQX, y difference in S_SQY
  assign diff_x = DIFF_W'(mem_x_q[idx_q]) - DIFF_W'(px_q);
  assign diff_y = DIFF_W'(mem_y_q[idx_q]) - DIFF_W'(py_q);
  assign mul_op = (state_q == S_SQY) ? diff_y : diff_x;
  assign prod   = mul_op * mul_op;

  assign dist_sq   = SUM_W'(sqx_q) + SUM_W'(sqy_q);
  assign hit       = cmp_valid_q && (RADIUS_W'(dist_sq) < radius_q);
  assign last_slot = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
  assign out_free  = !out_valid_q || out_o.ready;
  assign append    = (state_q == S_FINAL) && !hit && (count_q < CNT_W'(MAP_DEPTH));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (count_q == '0) ? S_FINAL : S_SQX;
        end
      end
      S_SQX: begin
        state_d = hit ? S_DONE : S_SQY;
      end
      S_SQY: begin
        state_d = last_slot ? S_FINAL : S_SQX;
      end
      S_FINAL: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radius_q    <= RADIUS_RESET;
      count_q     <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_write && (reg_idx == REG_MATCH_RADIUS_SQ)) begin
        radius_q <= pwdata[RADIUS_W-1:0];
      end
      if (in_fire) begin
        cmp_valid_q <= 1'b0;
      end else if (state_q == S_SQX) begin
        cmp_valid_q <= 1'b0;
      end else if (state_q == S_SQY) begin
        cmp_valid_q <= 1'b1;
      end
      if (append) begin
        count_q <= count_q + CNT_W'(1);
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      px_q  <= in_i.point_x;
      py_q  <= in_i.point_y;
      idx_q <= '0;
    end
    if (state_q == S_SQX) begin
      sqx_q <= prod[SQ_W-1:0];
    end
    if (state_q == S_SQY) begin
      sqy_q      <= prod[SQ_W-1:0];
      cmp_slot_q <= idx_q;
      if (!last_slot) begin
        idx_q <= idx_q + SLOT_W'(1);
      end
    end
    if (append) begin
      mem_x_q[count_q[SLOT_W-1:0]] <= px_q;
      mem_y_q[count_q[SLOT_W-1:0]] <= py_q;
    end
    if (((state_q == S_SQX) || (state_q == S_FINAL)) && hit) begin
      res_status_q <= STATUS_DUPLICATE;
      res_count_q  <= count_q;
      res_slot_q   <= cmp_slot_q;
    end else if (append) begin
      res_status_q <= STATUS_ADDED;
      res_count_q  <= count_q + CNT_W'(1);
      res_slot_q   <= count_q[SLOT_W-1:0];
    end else if (state_q == S_FINAL) begin
      res_status_q <= STATUS_FULL;
      res_count_q  <= count_q;
      res_slot_q   <= '0;
    end
    if ((state_q == S_DONE) && out_free) begin
      out_status_q <= res_status_q;
      out_count_q  <= POINT_COUNT_W'(res_count_q);
      out_slot_q   <= MATCH_SLOT_W'(res_slot_q);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.point_count = out_count_q;
  assign out_o.match_slot  = out_slot_q;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAP_DEPTH))
    else $error("point count beyond map depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("point count moved by more than one");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == STATUS_FULL)) |->
      (out_count_q == POINT_COUNT_W'(MAP_DEPTH)))
    else $error("full reported below map depth");

  a_added_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == STATUS_ADDED)) |->
      (out_slot_q == MATCH_SLOT_W'(out_count_q - POINT_COUNT_W'(1))))
    else $error("added slot does not match new count");

endmodule

// File: dv/proximity_dedup_point_map_top_test.sv
`timescale 1ns / 1ps

module proximity_dedup_point_map_top_test;
  import pdpm_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    status_e                  status;
    logic [POINT_COUNT_W-1:0] point_count;
    logic [MATCH_SLOT_W-1:0]  match_slot;
  } map_result_t;

  localparam logic [REG_IDX_W-1:0]  REG_UNUSED  = REG_IDX_W'(1);
  localparam logic [APB_ADDR_W-1:0] RADIUS_ADDR = {REG_MATCH_RADIUS_SQ, {REG_IDX_LSB{1'b0}}};
  localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = {REG_UNUSED, {REG_IDX_LSB{1'b0}}};
  localparam int unsigned MAX_PAUSE = 18;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  pdpm_in_if  in_if ();
  pdpm_out_if out_if ();

  proximity_dedup_point_map_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk_i = ~clk_i;

  coord_t              pts_x [MAP_DEPTH];
  coord_t              pts_y [MAP_DEPTH];
  int unsigned         pts_used;
  logic [RADIUS_W-1:0] radius_limit;
  map_result_t         expected_results [$];
  int unsigned         fail_count;
  bit                  quiet_flow;

  function automatic int unsigned draw_pause();
    return quiet_flow ? 0 : $urandom_range(0, MAX_PAUSE);
  endfunction

  function automatic map_result_t dedup_step(coord_t px, coord_t py);
    map_result_t res;
    longint      dx;
    longint      dy;
    bit          hit;
    int unsigned i;
    hit            = 1'b0;
    res.status     = STATUS_ADDED;
    res.match_slot = '0;
    for (i = 0; i < pts_used && !hit; i++) begin
      dx = longint'(pts_x[i]) - longint'(px);
      dy = longint'(pts_y[i]) - longint'(py);
      if (dx * dx + dy * dy < longint'(radius_limit)) begin
        hit            = 1'b1;
        res.match_slot = MATCH_SLOT_W'(i);
      end
    end
    if (hit) begin
      res.status = STATUS_DUPLICATE;
    end else if (pts_used < MAP_DEPTH) begin
      res.match_slot  = MATCH_SLOT_W'(pts_used);
      pts_x[pts_used] = px;
      pts_y[pts_used] = py;
      pts_used++;
    end else begin
      res.status = STATUS_FULL;
    end
    res.point_count = POINT_COUNT_W'(pts_used);
    return res;
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > 524287) return coord_t'(524287);
    if (v < -524288) return coord_t'(-524288);
    return coord_t'(v);
  endfunction

  task automatic send_point(input coord_t px, input coord_t py);
    int unsigned gap;
    gap = draw_pause();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.point_x <= px;
    in_if.point_y <= py;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    expected_results.push_back(dedup_step(px, py));
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (addr[APB_ADDR_W-1:REG_IDX_LSB] == REG_MATCH_RADIUS_SQ) begin
      radius_limit = word[RADIUS_W-1:0];
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_radius_readback();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= RADIUS_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== APB_DATA_W'(radius_limit)) begin
      $error("match_radius_sq readback: expected %0d, got %0d", radius_limit, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [APB_DATA_W-1:0] word);
    drain_results();
    apb_write(RADIUS_ADDR, word);
    check_radius_readback();
  endtask

  task automatic pick_candidate(output coord_t px, output coord_t py);
    int unsigned pick;
    int unsigned slot;
    int unsigned span;
    longint      reach;
    longint      ox;
    longint      oy;
    longint      t;
    reach = longint'($sqrt(real'(radius_limit)));
    span  = 32'(2 * reach + 4);
    pick  = $urandom_range(0, 99);
    if (pts_used == 0 || pick >= 85) begin
      px = coord_t'($urandom);
      py = coord_t'($urandom);
    end else begin
      slot = $urandom_range(0, pts_used - 1);
      ox   = 0;
      oy   = 0;
      if (pick >= 30) begin
        ox = longint'($urandom_range(0, span)) - (reach + 2);
        oy = longint'($urandom_range(0, span)) - (reach + 2);
      end else if (pick >= 15) begin
        // sit on or just inside the match circle
        ox = reach - longint'($urandom_range(0, 1));
        if ($urandom_range(0, 1) != 0) ox = -ox;
        if ($urandom_range(0, 1) != 0) begin
          t  = ox;
          ox = oy;
          oy = t;
        end
      end
      px = clamp_coord(longint'(pts_x[slot]) + ox);
      py = clamp_coord(longint'(pts_y[slot]) + oy);
    end
  endtask

  task automatic test_first_match_and_extremes();
    send_point(0, 0);
    send_point(0, 0);
    send_point(256, 0);
    send_point(255, 0);
    send_point(0, -256);
    send_point(-524288, -524288);
    send_point(524287, 524287);
    send_point(-524288, 524287);
    send_point(524287, -524288);
    send_point(524287, 524287 - 255);
    send_point(256, 255);
  endtask

  task automatic test_zero_radius_fill();
    int k;
    write_radius('0);
    send_point(0, 0);
    for (k = 1; k <= 8; k++) begin
      send_point(coord_t'(-4096 * k), coord_t'(4096 * k));
    end
    send_point(1, 1);
  endtask

  task automatic test_full_map_and_register();
    write_radius({APB_DATA_W{1'b1}});
    send_point(524287, 524287);
    send_point(-524288, -524288);
    write_radius({(APB_DATA_W - RADIUS_W)'($urandom), RADIUS_RESET});
    drain_results();
    apb_write(UNUSED_ADDR, '0);
    check_radius_readback();
    send_point(0, 0);
    send_point(100000, 100000);
  endtask

  task automatic test_radius_sweep();
    int unsigned         phase;
    int unsigned         n;
    int unsigned         i;
    int unsigned         k;
    logic [RADIUS_W-1:0] r;
    coord_t              px;
    coord_t              py;
    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          r = RADIUS_RESET;
          n = 150;
        end
        1: begin
          r = RADIUS_W'(1);
          n = 80;
        end
        2: begin
          r = RADIUS_W'({$urandom, $urandom});
          n = 100;
        end
        3: begin
          k = $urandom_range(1, 2048);
          r = RADIUS_W'(k * k);
          n = 120;
        end
        4: begin
          r = RADIUS_W'(1) << (RADIUS_W - 1);
          n = 60;
        end
        5: begin
          r = '0;
          n = 60;
        end
        default: begin
          r = RADIUS_W'($urandom_range(0, 1 << 22));
          n = 130;
        end
      endcase
      write_radius({(APB_DATA_W - RADIUS_W)'($urandom), r});
      quiet_flow = (phase % 3 == 1);
      for (i = 0; i < n; i++) begin
        if (i == n / 2) drain_results();
        pick_candidate(px, py);
        send_point(px, py);
      end
    end
    quiet_flow = 1'b0;
  endtask

  initial begin : result_sink
    int unsigned pause;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      pause = draw_pause();
      if (pause != 0) begin
        out_if.ready <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
    end
  end

  always @(posedge clk_i) begin : check_results
    map_result_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("item with no expectation: status %0d point_count %0d match_slot %0d",
               out_if.status, out_if.point_count, out_if.match_slot);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          fail_count++;
        end
        if (out_if.point_count !== want.point_count) begin
          $error("point_count: expected %0d, got %0d", want.point_count, out_if.point_count);
          fail_count++;
        end
        if (out_if.match_slot !== want.match_slot) begin
          $error("match_slot: expected %0d, got %0d", want.match_slot, out_if.match_slot);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.point_x <= '0;
    in_if.point_y <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    pts_used      = 0;
    radius_limit  = RADIUS_RESET;
    fail_count    = 0;
    quiet_flow    = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_match_and_extremes();
    test_zero_radius_fill();
    test_full_map_and_register();
    test_radius_sweep();
    drain_results();
    repeat (2 * MAP_DEPTH + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/pdpm_pkg.sv
rtl/pdpm_if.sv
rtl/proximity_dedup_point_map_top.sv
dv/proximity_dedup_point_map_top_test.sv
